[design/btd_pkg.sv]
// Shared types and constants for the block transposition decipher.
`default_nettype none

package btd_pkg;

  // Field widths fixed by the stream format
  localparam int KEY_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int BS_W     = 6;
  localparam int S_DATA_W = 24;
  localparam int KI_LSB   = 0;
  localparam int KV_LSB   = KI_LSB + KEY_W;
  localparam int CB_LSB   = KV_LSB + KEY_W;

  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [BS_W-1:0]   BS_RESET   = 6'd19;

  // tuser codes on the input side
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PLACE = 4'b0010,
    ST_READ  = 4'b0100,
    ST_LOAD  = 4'b1000
  } state_t;

  typedef struct packed {
    logic key_wr;    // write inverse table from the input transaction
    logic byte_cap;  // capture cipher byte and final flag
    logic place;     // place byte, advance fill count, rewind emit index
    logic load_out;  // move buffer read data into the output register
    logic k_inc;     // advance emit index
    logic buf_clr;   // mark buffer empty, zero fill count
  } btd_cmd_t;

  typedef struct packed {
    logic flush;     // block complete or final byte seen
    logic last_k;    // emit index is on the last byte of the block
    logic out_free;  // output register can take a byte
  } btd_sts_t;

endpackage

`default_nettype wire

[design/btd_ctrl.sv]
// Controller state machine for the block transposition decipher.
`default_nettype none

module btd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tuser,
  output logic              s_axis_tready,
  input  btd_pkg::btd_sts_t sts,
  output btd_pkg::btd_cmd_t cmd
);
  import btd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == KIND_KEY) begin
            cmd.key_wr = 1'b1;
          end else begin
            cmd.byte_cap = 1'b1;
            state_next   = ST_PLACE;
          end
        end
      end
      ST_PLACE: begin
        cmd.place  = 1'b1;
        state_next = sts.flush ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        // buffer read data lands next cycle
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.last_k) begin
            cmd.buf_clr = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            cmd.k_inc  = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/btd_datapath.sv]
// Datapath: key inverse table, block buffer, counters and output register.
`default_nettype none

module btd_datapath #(
  parameter int MAX_BLOCK = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [btd_pkg::BS_W-1:0]      cfg_data,
  input  logic [btd_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input  logic                          s_axis_tlast,
  input  btd_pkg::btd_cmd_t             cmd,
  output btd_pkg::btd_sts_t             sts,
  output logic [btd_pkg::BYTE_W-1:0]    m_axis_tdata,
  output logic                          m_axis_tvalid,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser,
  input  logic                          m_axis_tready
);
  import btd_pkg::*;

  localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int FW = $clog2(MAX_BLOCK + 1);
  localparam int CW = (FW > BS_W) ? FW : BS_W;

  logic [BS_W-1:0]   blk_len;
  logic [CW-1:0]     bs_ext;
  logic [FW-1:0]     bs;
  logic [KEY_W-1:0]  key_index;
  logic [KEY_W-1:0]  key_value;
  logic [KEY_W-1:0]  inv_mem [MAX_BLOCK];
  logic [KEY_W-1:0]  inv_rd;
  logic [BYTE_W-1:0] buf_mem [MAX_BLOCK];
  logic [BYTE_W-1:0] buf_rd;
  logic              buf_rd_ok;
  logic [MAX_BLOCK-1:0] filled;
  logic [BYTE_W-1:0] byte_q;
  logic              final_q;
  logic [FW-1:0]     fill_count;
  logic [FW-1:0]     fill_inc;
  logic [FW-1:0]     k;
  logic [FW-1:0]     k_inc;
  logic              place_ok;

  assign key_index = s_axis_tdata[KI_LSB +: KEY_W];
  assign key_value = s_axis_tdata[KV_LSB +: KEY_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_len <= BS_RESET;
    end else if (cfg_we) begin
      blk_len <= cfg_data;
    end
  end

  // Clamp block size into 1..MAX_BLOCK
  always_comb begin
    if (blk_len == '0) begin
      bs_ext = CW'(1);
    end else if (CW'(blk_len) > CW'(MAX_BLOCK)) begin
      bs_ext = CW'(MAX_BLOCK);
    end else begin
      bs_ext = CW'(blk_len);
    end
  end
  assign bs = FW'(bs_ext);

  // Inverse key table: written on key load, read at the fill position
  always_ff @(posedge clk) begin
    if (cmd.key_wr && (CW'(key_value) < CW'(MAX_BLOCK))) begin
      inv_mem[AW'(key_value)] <= key_index;
    end
    inv_rd <= inv_mem[fill_count[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_cap) begin
      byte_q  <= s_axis_tdata[CB_LSB +: BYTE_W];
      final_q <= s_axis_tlast;
    end
  end

  assign fill_inc = fill_count + FW'(1);
  assign k_inc    = k + FW'(1);
  assign place_ok = (fill_count < bs) && (CW'(inv_rd) < CW'(bs));

  // Block buffer; entries not marked filled read as space
  always_ff @(posedge clk) begin
    if (cmd.place && place_ok) begin
      buf_mem[AW'(inv_rd)] <= byte_q;
    end
    buf_rd <= buf_mem[k[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      buf_rd_ok <= 1'b0;
    end else begin
      buf_rd_ok <= filled[k[AW-1:0]];
      if (cmd.buf_clr) begin
        filled <= '0;
      end else if (cmd.place && place_ok) begin
        filled[AW'(inv_rd)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      k          <= '0;
    end else begin
      if (cmd.buf_clr) begin
        fill_count <= '0;
      end else if (cmd.place) begin
        fill_count <= fill_inc;
      end
      if (cmd.place) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k_inc;
      end
    end
  end

  assign sts.flush    = (fill_inc >= bs) || final_q;
  assign sts.last_k   = (k_inc == fill_count);
  assign sts.out_free = !m_axis_tvalid || m_axis_tready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_axis_tdata <= buf_rd_ok ? buf_rd : SPACE_CHAR;
      m_axis_tlast <= sts.last_k;
      m_axis_tuser <= sts.last_k && final_q;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("output register overwritten while pending");

  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(MAX_BLOCK))
    else $error("fill count beyond buffer depth");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.buf_clr |=> (filled == '0))
    else $error("buffer not empty after flush");

  a_text_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("text end without block end");

endmodule

`default_nettype wire

[design/block_transposition_decipher.sv]
// Top level of the block transposition decipher.
//
//  channel  | dir | handshake                     | payload
//  s_axis   | in  | tvalid/tready                 | tdata, tuser=kind, tlast=final_byte
//  m_axis   | out | tvalid/tready                 | tdata=plain_byte, tlast/tuser
//  cfg      | in  | cfg_we, no back-pressure      | cfg_data=block length
//
// A key load is taken in idle; a cipher byte is accepted, then placed via
// the registered inverse-table read. A completed block emits byte by byte
// through the buffer's single registered read port, plus stalls on
// m_axis_tready; no input is taken meanwhile. The last emitted byte may wait
// in the output register while the next input transaction is taken. Reset
// sets the length to 19, marks the buffer empty at once; no clearing pass.
`default_nettype none

module block_transposition_decipher #(
  parameter int MAX_BLOCK = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // key_index[4:0], key_value[9:5], cipher_byte[17:10]
  input  logic        s_axis_tuser,   // kind
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // plain_byte[7:0]
  output logic        m_axis_tuser,   // text_end
  output logic        m_axis_tlast    // block_end
);
  import btd_pkg::*;

  btd_cmd_t cmd;
  btd_sts_t sts;

  btd_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  btd_datapath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .cmd           (cmd),
    .sts           (sts),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tready (m_axis_tready)
  );

endmodule

`default_nettype wire

[dv/block_transposition_decipher_tb.sv]
// Self-checking testbench for the block transposition decipher.
`timescale 1ns / 100ps

module block_transposition_decipher_tb;
  import btd_pkg::*;

  localparam int MAX_BLK       = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 170;

  typedef struct {
    logic [BYTE_W-1:0] plain;
    logic              blk_end;
    logic              txt_end;
  } plain_rec_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [5:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // key_index[4:0], key_value[9:5], cipher_byte[17:10]
  logic        s_axis_tuser;   // kind
  logic        s_axis_tlast;   // final_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // plain_byte[7:0]
  logic        m_axis_tuser;   // text_end
  logic        m_axis_tlast;   // block_end

  // Predictor state
  logic [KEY_W-1:0]  inv_key [MAX_BLK];
  logic [BYTE_W-1:0] blk_buf [MAX_BLK];
  int                fill_cnt;
  logic [BS_W-1:0]   blk_size;
  plain_rec_t        plain_q[$];

  int mismatches = 0;
  int burst_left = 0;
  int stall_pct  = 30;
  bit steady     = 1'b0;

  block_transposition_decipher #(.MAX_BLOCK(MAX_BLK)) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("block_transposition_decipher_tb: done, errors");
    $finish;
  end

  // Receiver: random stalls, now and then a long hold-off
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct > 0 && $urandom_range(0, 63) == 0) begin
        hold = $urandom_range(4, 16);
        m_axis_tready = 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic int active_size(input logic [BS_W-1:0] bs);
    if (bs == 0) return 1;
    if (bs > MAX_BLK) return MAX_BLK;
    return int'(bs);
  endfunction

  function automatic void decipher_step(input logic kind, input logic [KEY_W-1:0] ki,
                                        input logic [KEY_W-1:0] kv,
                                        input logic [BYTE_W-1:0] cb, input logic fin);
    int bs;
    int n;
    int pos;
    plain_rec_t rec;
    bs = active_size(blk_size);
    if (kind == KIND_KEY) begin
      inv_key[kv] = ki;
      return;
    end
    // a byte past a lowered block size still counts but is not placed
    if (fill_cnt < bs) begin
      pos = int'(inv_key[fill_cnt]);
      if (pos < bs) blk_buf[pos] = cb;
    end
    fill_cnt++;
    if (fill_cnt < bs && !fin) return;
    n = (fill_cnt > MAX_BLK) ? MAX_BLK : fill_cnt;
    for (int k = 0; k < n; k++) begin
      rec.plain   = blk_buf[k];
      rec.blk_end = (k == n - 1);
      rec.txt_end = (k == n - 1) && fin;
      plain_q.push_back(rec);
    end
    foreach (blk_buf[i]) blk_buf[i] = SPACE_CHAR;
    fill_cnt = 0;
  endfunction

  // Check results first, then predict from the input transaction of this edge
  always @(posedge clk) begin
    plain_rec_t want;
    if (rst) begin
      blk_size = BS_RESET;
      fill_cnt = 0;
      foreach (blk_buf[i]) blk_buf[i] = SPACE_CHAR;
      plain_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (plain_q.size() == 0) begin
          $display("%0t: unexpected result plain_byte %h block_end %b text_end %b",
                   $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
          mismatches++;
        end else begin
          want = plain_q.pop_front();
          if (m_axis_tdata !== want.plain) begin
            $display("%0t: plain_byte expected %h actual %h", $time, want.plain, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tlast !== want.blk_end) begin
            $display("%0t: block_end expected %b actual %b", $time, want.blk_end, m_axis_tlast);
            mismatches++;
          end
          if (m_axis_tuser !== want.txt_end) begin
            $display("%0t: text_end expected %b actual %b", $time, want.txt_end, m_axis_tuser);
            mismatches++;
          end
        end
      end
      if (cfg_we) blk_size = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        decipher_step(s_axis_tuser, s_axis_tdata[KI_LSB +: KEY_W],
                      s_axis_tdata[KV_LSB +: KEY_W], s_axis_tdata[CB_LSB +: BYTE_W],
                      s_axis_tlast);
    end
  end

  task automatic send_item(input logic kind, input logic [KEY_W-1:0] ki,
                           input logic [KEY_W-1:0] kv, input logic [BYTE_W-1:0] cb,
                           input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = steady ? 1000 : $urandom_range(1, 12);
      if (!steady) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    s_axis_tdata                    = '0;
    s_axis_tdata[KI_LSB +: KEY_W]   = ki;
    s_axis_tdata[KV_LSB +: KEY_W]   = kv;
    s_axis_tdata[CB_LSB +: BYTE_W]  = cb;
    s_axis_tuser                    = kind;
    s_axis_tlast                    = fin;
    s_axis_tvalid                   = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
  endtask

  // Unused fields carry noise; the block must ignore them
  task automatic send_key(input logic [KEY_W-1:0] ki, input logic [KEY_W-1:0] kv);
    send_item(KIND_KEY, ki, kv, BYTE_W'($urandom), 1'($urandom));
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] cb, input logic fin);
    send_item(KIND_BYTE, KEY_W'($urandom), KEY_W'($urandom), cb, fin);
  endtask

  // Drop valid, wait for every expected byte, then let any placement finish
  task automatic drain_and_settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (plain_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_size(input logic [BS_W-1:0] bs);
    drain_and_settle();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = bs;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // Lower half identity, upper half reversed: covers dropped placements at size 19
  task automatic test_key_extremes();
    for (int v = 0; v < MAX_BLK; v++)
      send_key(KEY_W'((v < 16) ? v : 47 - v), KEY_W'(v));
  endtask

  task automatic test_default_size();
    for (int k = 0; k < 19; k++)
      send_byte((k == 0) ? 8'h00 : (k == 18) ? 8'hFF : BYTE_W'($urandom), 1'b0);
  endtask

  task automatic test_size_extremes();
    write_block_size(6'd1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    write_block_size(6'd0);
    send_byte(8'h3C, 1'b0);
    write_block_size(6'd63);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
  endtask

  task automatic test_size_lowered();
    write_block_size(6'd8);
    repeat (5) send_byte(BYTE_W'($urandom), 1'b0);
    write_block_size(6'd3);
    send_byte(8'h77, 1'b0);
    // final byte into an empty block
    write_block_size(6'd8);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_random_stream();
    int sent;
    int phase_len;
    int r;
    int j;
    int tmp;
    int perm[MAX_BLK];
    logic [BS_W-1:0] bs;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      case (r)
        0: bs = 6'd0;
        1: bs = 6'd1;
        2: bs = 6'd32;
        3: bs = BS_W'($urandom_range(33, 63));
        default: bs = BS_W'($urandom_range(1, 32));
      endcase
      write_block_size(bs);
      r = $urandom_range(0, 2);
      stall_pct = (r == 0) ? 0 : (r == 1) ? 25 : 60;
      steady    = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        foreach (perm[i]) perm[i] = i;
        for (int i = MAX_BLK - 1; i > 0; i--) begin
          j       = $urandom_range(0, i);
          tmp     = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int v = 0; v < MAX_BLK; v++) send_key(KEY_W'(perm[v]), KEY_W'(v));
        sent += MAX_BLK;
      end
      phase_len = $urandom_range(10, 50);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 8) send_key(KEY_W'($urandom), KEY_W'($urandom));
        else send_byte(BYTE_W'($urandom), r >= 94);
        sent++;
      end
      // leave some phases open so the next size change lands mid-block
      if ($urandom_range(0, 1) == 0) begin
        send_byte(BYTE_W'($urandom), 1'b1);
        sent++;
      end
    end
    send_byte(BYTE_W'($urandom), 1'b1);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_KEY;
    s_axis_tlast  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_key_extremes();
    test_default_size();
    test_size_extremes();
    test_size_lowered();
    test_random_stream();
    drain_and_settle();

    if (mismatches == 0 && plain_q.size() == 0) begin
      $display("block_transposition_decipher_tb: done, clean");
    end else begin
      $display("block_transposition_decipher_tb: done, errors");
    end
    $finish;
  end

endmodule
